/* hw/rtl/vrd_pkg.sv */
// Shared types, constants and the octant sine/cosine table of the vector rotator.
// No dependencies; used by every other file of the block except vrd_checker.

package vrd_pkg;

    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam int ANGLE_W   = 16;

    localparam int DEG_FULL = 360;
    localparam int DEG_QUAD = 90;
    localparam int DEG_OCT  = 45;

    // Bias keeps the angle sum positive (multiple of 360); floor(u * RECIP / 2^SHIFT)
    // is then at most one below u / 360.
    localparam int ANG_BIAS    = 36360;
    localparam int ANG_U_W     = 17;
    localparam int RECIP_360   = 11650;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = 31;

    localparam int TAB_DEPTH = 46;
    localparam int TAB_IDX_W = 6;
    localparam int TAB_MAG_W = 31;

    // pi/180 in Q30
    localparam logic [63:0] DEG_TO_RAD_Q30 = 64'd18740330;
    localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF       = 64'd1 << 29;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_v;
        logic signed [COEF_W-1:0] sin_v;
        logic signed [COEF_W-1:0] nsin_v;
    } t_coef;

    typedef logic [TAB_DEPTH-1:0][2*TAB_MAG_W-1:0] t_trig_tab;

    // Horner-form Taylor series for 0..45 degrees, entry = {cos, sin} in unsigned Q30
    function automatic t_trig_tab build_trig_tab();
        t_trig_tab   tab;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] cv;
        logic [63:0] sv;
        for (int r = 0; r < TAB_DEPTH; r++) begin
            t  = 64'(r) * DEG_TO_RAD_Q30;
            t2 = (t * t + Q30_HALF) >> 30;

            p  = Q30_ONE - t2 / 64'd72;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd42;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd20;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd6;
            sv = (t * p) >> 30;

            p  = Q30_ONE - t2 / 64'd90;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd56;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd30;
            p  = Q30_ONE - ((t2 * p) >> 30) / 64'd12;
            cv = Q30_ONE - ((t2 * p) >> 30) / 64'd2;

            tab[r] = {cv[TAB_MAG_W-1:0], sv[TAB_MAG_W-1:0]};
        end
        return tab;
    endfunction

    localparam t_trig_tab TRIG_TAB = build_trig_tab();

endpackage

/* hw/rtl/vrd_trig.sv */
// Angle front end: reduce degrees modulo 360, fold to an octant, look up and unfold
// cosine and sine. Four stages; the vector rides along. Depends on vrd_pkg.

module vrd_trig #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_vec_x,
    input  logic signed [DATA_WIDTH-1:0]        i_vec_y,
    input  logic signed [vrd_pkg::ANGLE_W-1:0]  i_angle_deg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]        o_vec_x,
    output logic signed [DATA_WIDTH-1:0]        o_vec_y,
    output vrd_pkg::t_coef                      o_coef
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   en;

    logic signed [DATA_WIDTH-1:0] r_x [NSTG];
    logic signed [DATA_WIDTH-1:0] r_y [NSTG];

    logic signed [vrd_pkg::ANG_U_W:0]     ang_sum;
    logic [vrd_pkg::ANG_U_W-1:0]          n_u;
    logic [vrd_pkg::ANG_U_W-1:0]          r_u;
    logic [vrd_pkg::PROD_W-1:0]           r_prod;

    logic [vrd_pkg::PROD_W-vrd_pkg::RECIP_SHIFT-1:0] quo;
    logic [vrd_pkg::ANG_U_W-1:0]          rem;
    logic [vrd_pkg::ANG_U_W-1:0]          n_a;
    logic [8:0]                           r_a;

    vrd_pkg::t_quad                       n_quad;
    logic [8:0]                           base;
    logic [6:0]                           oct_r;
    logic [vrd_pkg::TAB_IDX_W-1:0]        n_idx;
    vrd_pkg::t_quad                       r_quad;
    logic                                 r_swap;
    logic [vrd_pkg::TAB_IDX_W-1:0]        r_idx;

    logic [2*vrd_pkg::TAB_MAG_W-1:0]      entry;
    logic [vrd_pkg::TAB_MAG_W-1:0]        c_mag;
    logic [vrd_pkg::TAB_MAG_W-1:0]        s_mag;
    logic signed [vrd_pkg::COEF_W-1:0]    c0;
    logic signed [vrd_pkg::COEF_W-1:0]    s0;
    vrd_pkg::t_coef                       n_coef;
    vrd_pkg::t_coef                       r_coef;

    always_comb begin
        en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld = {r_vld[NSTG-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x[0] <= i_vec_x;
            r_y[0] <= i_vec_y;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                r_x[k] <= r_x[k-1];
                r_y[k] <= r_y[k-1];
            end
        end
    end

    // stage 1: bias and reciprocal product
    assign ang_sum = (vrd_pkg::ANG_U_W+1)'(i_angle_deg)
                   + (vrd_pkg::ANG_U_W+1)'(vrd_pkg::ANG_BIAS);
    assign n_u     = ang_sum[vrd_pkg::ANG_U_W-1:0];

    // stage 2: remainder with one correction step
    assign quo = r_prod[vrd_pkg::PROD_W-1:vrd_pkg::RECIP_SHIFT];

    always_comb begin
        rem = r_u - vrd_pkg::ANG_U_W'(quo) * vrd_pkg::ANG_U_W'(vrd_pkg::DEG_FULL);
        n_a = rem;
        if (rem >= vrd_pkg::ANG_U_W'(vrd_pkg::DEG_FULL)) begin
            n_a = rem - vrd_pkg::ANG_U_W'(vrd_pkg::DEG_FULL);
        end
    end

    // stage 3: quadrant and octant fold
    always_comb begin
        priority if (r_a >= 9'(3 * vrd_pkg::DEG_QUAD)) begin
            n_quad = vrd_pkg::QUAD_270;
            base   = 9'(3 * vrd_pkg::DEG_QUAD);
        end else if (r_a >= 9'(2 * vrd_pkg::DEG_QUAD)) begin
            n_quad = vrd_pkg::QUAD_180;
            base   = 9'(2 * vrd_pkg::DEG_QUAD);
        end else if (r_a >= 9'(vrd_pkg::DEG_QUAD)) begin
            n_quad = vrd_pkg::QUAD_90;
            base   = 9'(vrd_pkg::DEG_QUAD);
        end else begin
            n_quad = vrd_pkg::QUAD_0;
            base   = '0;
        end
        oct_r = 7'(r_a - base);
        if (oct_r > 7'(vrd_pkg::DEG_OCT)) begin
            n_idx = vrd_pkg::TAB_IDX_W'(7'(vrd_pkg::DEG_QUAD) - oct_r);
        end else begin
            n_idx = vrd_pkg::TAB_IDX_W'(oct_r);
        end
    end

    // stage 4: table read, swap across the octant, unfold by quadrant
    always_comb begin
        entry = vrd_pkg::TRIG_TAB[r_idx];
        c_mag = entry[2*vrd_pkg::TAB_MAG_W-1:vrd_pkg::TAB_MAG_W];
        s_mag = entry[vrd_pkg::TAB_MAG_W-1:0];
        if (r_swap) begin
            c0 = $signed({1'b0, s_mag});
            s0 = $signed({1'b0, c_mag});
        end else begin
            c0 = $signed({1'b0, c_mag});
            s0 = $signed({1'b0, s_mag});
        end
        unique case (r_quad)
            vrd_pkg::QUAD_0: begin
                n_coef.cos_v = c0;
                n_coef.sin_v = s0;
            end
            vrd_pkg::QUAD_90: begin
                n_coef.cos_v = -s0;
                n_coef.sin_v = c0;
            end
            vrd_pkg::QUAD_180: begin
                n_coef.cos_v = -c0;
                n_coef.sin_v = -s0;
            end
            default: begin
                n_coef.cos_v = s0;
                n_coef.sin_v = -c0;
            end
        endcase
        n_coef.nsin_v = -n_coef.sin_v;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_u    <= n_u;
            r_prod <= vrd_pkg::PROD_W'(n_u) * vrd_pkg::PROD_W'(vrd_pkg::RECIP_360);
        end
        if (en[1]) begin
            r_a <= n_a[8:0];
        end
        if (en[2]) begin
            r_quad <= n_quad;
            r_swap <= (oct_r > 7'(vrd_pkg::DEG_OCT));
            r_idx  <= n_idx;
        end
        if (en[3]) begin
            r_coef <= n_coef;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_vec_x = r_x[NSTG-1];
    assign o_vec_y = r_y[NSTG-1];
    assign o_coef  = r_coef;

endmodule

/* hw/rtl/vrd_mac.sv */
// Rotation multiply-accumulate: split partial products, exact Q30 sums with
// round-half-up, then saturation into the output register. Depends on vrd_pkg.

module vrd_mac #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_x,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_y,
    input  vrd_pkg::t_coef                i_coef,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_rot_x,
    output logic signed [DATA_WIDTH-1:0]  o_rot_y
);

    localparam int NSTG = 3;
    localparam int LO_W = DATA_WIDTH / 2;
    localparam int HI_W = DATA_WIDTH - LO_W;
    localparam int PH_W = HI_W + vrd_pkg::COEF_W;
    localparam int PL_W = LO_W + 1 + vrd_pkg::COEF_W;
    localparam int SUMW = DATA_WIDTH + 34;
    localparam int SHW  = SUMW - vrd_pkg::COEF_FRAC;

    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (vrd_pkg::COEF_FRAC - 1);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   en;

    logic signed [HI_W-1:0] xh;
    logic signed [HI_W-1:0] yh;
    logic signed [LO_W:0]   xl;
    logic signed [LO_W:0]   yl;

    logic signed [PH_W-1:0] r_pxh_c;
    logic signed [PH_W-1:0] r_pyh_ns;
    logic signed [PH_W-1:0] r_pxh_s;
    logic signed [PH_W-1:0] r_pyh_c;
    logic signed [PL_W-1:0] r_pxl_c;
    logic signed [PL_W-1:0] r_pyl_ns;
    logic signed [PL_W-1:0] r_pxl_s;
    logic signed [PL_W-1:0] r_pyl_c;

    logic signed [SUMW-1:0] n_sum_x;
    logic signed [SUMW-1:0] n_sum_y;
    logic signed [SUMW-1:0] r_sum_x;
    logic signed [SUMW-1:0] r_sum_y;

    logic signed [DATA_WIDTH-1:0] r_rot_x;
    logic signed [DATA_WIDTH-1:0] r_rot_y;

    function automatic logic signed [DATA_WIDTH-1:0] saturate(
        input logic signed [SUMW-1:0] s
    );
        logic signed [SHW-1:0]        v;
        logic [SHW-DATA_WIDTH:0]      top;
        v   = s[SUMW-1:vrd_pkg::COEF_FRAC];
        top = v[SHW-1:DATA_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[DATA_WIDTH-1:0];
        end else if (v[SHW-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    always_comb begin
        en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld = {r_vld[NSTG-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign xh = i_vec_x[DATA_WIDTH-1:LO_W];
    assign yh = i_vec_y[DATA_WIDTH-1:LO_W];
    assign xl = $signed({1'b0, i_vec_x[LO_W-1:0]});
    assign yl = $signed({1'b0, i_vec_y[LO_W-1:0]});

    assign n_sum_x = ((SUMW'(r_pxh_c) + SUMW'(r_pyh_ns)) <<< LO_W)
                   + SUMW'(r_pxl_c) + SUMW'(r_pyl_ns) + HALF;
    assign n_sum_y = ((SUMW'(r_pxh_s) + SUMW'(r_pyh_c)) <<< LO_W)
                   + SUMW'(r_pxl_s) + SUMW'(r_pyl_c) + HALF;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pxh_c  <= xh * i_coef.cos_v;
            r_pyh_ns <= yh * i_coef.nsin_v;
            r_pxh_s  <= xh * i_coef.sin_v;
            r_pyh_c  <= yh * i_coef.cos_v;
            r_pxl_c  <= xl * i_coef.cos_v;
            r_pyl_ns <= yl * i_coef.nsin_v;
            r_pxl_s  <= xl * i_coef.sin_v;
            r_pyl_c  <= yl * i_coef.cos_v;
        end
        if (en[1]) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
        if (en[2]) begin
            r_rot_x <= saturate(r_sum_x);
            r_rot_y <= saturate(r_sum_y);
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;

endmodule

/* hw/rtl/vector_rotate_degrees_top.sv */
// Top level of the 2D vector rotator by whole degrees.
// Instantiates vrd_trig and vrd_mac; depends on vrd_pkg.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+----------------------------------
//   in      | i_valid | o_ready | i_vec_x, i_vec_y, i_angle_deg
//   out     | o_valid | i_ready | o_rot_x, o_rot_y
//
// One beat per cycle sustained while the output side takes results; the angle
// reduction and table path comes first, then the split multiply, sum and saturate path.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall holds only the stages that are full; empty stages keep filling,
// so the input side keeps accepting beats while a result waits, until all
// seven stages are full.

module vector_rotate_degrees_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_vec_x,
    input  logic signed [DATA_WIDTH-1:0]        i_vec_y,
    input  logic signed [vrd_pkg::ANGLE_W-1:0]  i_angle_deg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]        o_rot_x,
    output logic signed [DATA_WIDTH-1:0]        o_rot_y
);

    logic                         trig_valid;
    logic                         mac_ready;
    logic signed [DATA_WIDTH-1:0] trig_x;
    logic signed [DATA_WIDTH-1:0] trig_y;
    vrd_pkg::t_coef               trig_coef;

    vrd_trig #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_angle_deg (i_angle_deg),
        .o_valid     (trig_valid),
        .i_ready     (mac_ready),
        .o_vec_x     (trig_x),
        .o_vec_y     (trig_y),
        .o_coef      (trig_coef)
    );

    vrd_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (trig_valid),
        .o_ready (mac_ready),
        .i_vec_x (trig_x),
        .i_vec_y (trig_y),
        .i_coef  (trig_coef),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y)
    );

endmodule

/* hw/rtl/vrd_checker.sv */
// Port-level checks of the vector rotator: reset, back-pressure and latency.
// Bound to vector_rotate_degrees_top; no package dependency.

module vrd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [DATA_WIDTH-1:0] o_rot_x,
    input logic [DATA_WIDTH-1:0] o_rot_y
);

    // empty output stage or a taken result frees the whole pipe
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input side stalled while output side is free");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present right after reset");

    // with no back-pressure an accepted beat reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready) ##1 i_ready ##1 i_ready ##1 i_ready
        ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("accepted beat did not arrive after seven free cycles");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rot_x) && $stable(o_rot_y)))
        else $error("stalled result beat dropped or changed");

endmodule

bind vector_rotate_degrees_top vrd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_vrd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rot_x (o_rot_x),
    .o_rot_y (o_rot_y)
);
